[src/gq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gq_pkg: shared types and constants for the gamma-2 color quantizer
// Widths of the channel sums, the root search state and the pixel bundle.
// ----------------------------------------------------------------------------
package gq_pkg;

    // input sum width (16 fraction bits included)
    localparam int SUM_W     = 40;
    // sample count register width
    localparam int CNT_W     = 16;
    // one output byte per channel
    localparam int ROOT_W    = 8;
    localparam int BIT_IDX_W = 3;
    // k*k*n stays below 2^32, k*n below 2^24
    localparam int SQ_W      = 2 * ROOT_W + CNT_W;
    localparam int KN_W      = ROOT_W + CNT_W;
    // compare width covers both the sum and the square
    localparam int CMP_W     = (SUM_W > SQ_W) ? SUM_W : SQ_W;

    // channel lanes, red high
    localparam int NUM_CH = 3;
    localparam int CH_RED = 2;
    localparam int CH_GRN = 1;
    localparam int CH_BLU = 0;

    // square root search state of one channel
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [ROOT_W-1:0] root;
        logic [SQ_W-1:0]   sq;
        logic [KN_W-1:0]   kn;
    } gq_chan_t;

    typedef gq_chan_t [NUM_CH-1:0] gq_pix_t;

endpackage
`default_nettype wire

[src/gamma2_color_quantizer_unit.sv]
// Throughput: one pixel per cycle while the output is ready; one pipeline stage per root bit, 8 stages.
// Stalls back up stage by stage; empty stages keep accepting while a result waits.
// Reset: asynchronous active low, clears all valid bits, sample count returns to 1.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gamma2_color_quantizer_unit: accumulated RGB sums to a packed 24-bit color
// Each byte is the largest k with k*k*sample_count <= sum, found bit by bit.
// ----------------------------------------------------------------------------
module gamma2_color_quantizer_unit (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [gq_pkg::CNT_W-1:0] sample_count,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [gq_pkg::SUM_W-1:0] red_sum,
    input  wire logic [gq_pkg::SUM_W-1:0] green_sum,
    input  wire logic [gq_pkg::SUM_W-1:0] blue_sum,
    input  wire logic [2:0]               invalid_mask,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [3*gq_pkg::ROOT_W-1:0]   packed_color
);
    import gq_pkg::*;

    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] n_next;
    gq_pix_t          pix_in;
    gq_pix_t          pix   [0:ROOT_W];
    logic             vld   [0:ROOT_W];
    logic             rdy   [0:ROOT_W];

    // sample count, zero taken as one
    assign cfg_ready = 1'b1;

    always_comb
    begin
        n_next = n_reg;
        if (cfg_valid)
            n_next = (sample_count == '0) ? CNT_W'(1) : sample_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_reg <= CNT_W'(1);
        else
            n_reg <= n_next;
    end

    // initial search state, invalid channels forced to zero
    always_comb
    begin
        pix_in = '0;
        pix_in[CH_RED].sum = invalid_mask[CH_RED] ? '0 : red_sum;
        pix_in[CH_GRN].sum = invalid_mask[CH_GRN] ? '0 : green_sum;
        pix_in[CH_BLU].sum = invalid_mask[CH_BLU] ? '0 : blue_sum;
    end

    assign pix[0]   = pix_in;
    assign vld[0]   = in_valid;
    assign in_ready = rdy[0];

    // one stage per root bit, msb first
    for (genvar s = 0; s < ROOT_W; s++)
    begin : g_stage
        gq_pipe_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .bit_idx  (BIT_IDX_W'(ROOT_W - 1 - s)),
            .n        (n_reg),
            .up_valid (vld[s]),
            .up_ready (rdy[s]),
            .up_data  (pix[s]),
            .dn_valid (vld[s+1]),
            .dn_ready (rdy[s+1]),
            .dn_data  (pix[s+1])
        );
    end

    // result, red high
    assign out_valid    = vld[ROOT_W];
    assign rdy[ROOT_W]  = out_ready;
    assign packed_color = {pix[ROOT_W][CH_RED].root,
                           pix[ROOT_W][CH_GRN].root,
                           pix[ROOT_W][CH_BLU].root};

endmodule
`default_nettype wire

[src/gq_root_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gq_root_step: one bit of the integer square root search
// Tries root|bit against the sum, keeping root^2*n and root*n incrementally
// so that the step needs only shifts, one add tree and one compare.
// ----------------------------------------------------------------------------
module gq_root_step (
    input  wire logic [gq_pkg::BIT_IDX_W-1:0] bit_idx,
    input  wire logic [gq_pkg::CNT_W-1:0]     n,
    input  wire gq_pkg::gq_chan_t             cur,
    output gq_pkg::gq_chan_t                  nxt
);
    import gq_pkg::*;

    logic [SQ_W-1:0]  cross_term;
    logic [SQ_W-1:0]  lead;
    logic [SQ_W-1:0]  cand;
    logic [CMP_W-1:0] cand_ext;
    logic [CMP_W-1:0] sum_ext;
    logic             take;

    // (k+b)^2*n = k^2*n + 2*b*k*n + b^2*n
    always_comb
    begin
        cross_term = SQ_W'(cur.kn) << ({1'b0, bit_idx} + 4'd1);
        lead       = SQ_W'(n) << {bit_idx, 1'b0};
        cand       = cur.sq + cross_term + lead;
        cand_ext   = CMP_W'(cand);
        sum_ext    = CMP_W'(cur.sum);
        take       = (cand_ext <= sum_ext);
    end

    // keep the bit when the candidate square still fits
    always_comb
    begin
        nxt = cur;
        if (take)
        begin
            nxt.root = cur.root | (ROOT_W'(1) << bit_idx);
            nxt.sq   = cand;
            nxt.kn   = cur.kn + (KN_W'(n) << bit_idx);
        end
    end

endmodule
`default_nettype wire

[src/gq_pipe_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gq_pipe_stage: one registered pipeline stage of the root search
// Resolves one root bit on all three channels, with valid/ready flow control.
// ----------------------------------------------------------------------------
module gq_pipe_stage (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [gq_pkg::BIT_IDX_W-1:0] bit_idx,
    input  wire logic [gq_pkg::CNT_W-1:0]     n,
    input  wire logic                         up_valid,
    output logic                              up_ready,
    input  wire gq_pkg::gq_pix_t              up_data,
    output logic                              dn_valid,
    input  wire logic                         dn_ready,
    output gq_pkg::gq_pix_t                   dn_data
);
    import gq_pkg::*;

    gq_pix_t step_data;
    gq_pix_t data_reg;
    logic    valid_reg;
    logic    valid_next;

    // one search step per channel
    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_ch
        gq_root_step u_step (
            .bit_idx (bit_idx),
            .n       (n),
            .cur     (up_data[c]),
            .nxt     (step_data[c])
        );
    end

    // stage takes a request when empty or draining
    always_comb
    begin
        up_ready   = !valid_reg || dn_ready;
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= step_data;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule
`default_nettype wire

[src/gq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gq_checker: port level checks for the quantizer
// Output hold rules, flow through readiness and reset state.
// ----------------------------------------------------------------------------
module gq_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_ready,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic [3*gq_pkg::ROOT_W-1:0] packed_color
);
    import gq_pkg::*;

    // a stalled result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(packed_color))
        else $error("result changed while stalled");

    // with the sink ready the whole pipeline flows
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output drains");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result present after reset");

endmodule

bind gamma2_color_quantizer_unit gq_checker u_gq_checker (.*);
`default_nettype wire

[tb/gq_color_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gq_color_checker: scoreboard for the gamma-2 color quantizer
// Watches the sample count, pixel and color channels, predicts each packed
// color from the accepted pixel and the live sample count, and compares the
// colors in order, one byte lane at a time.
// ----------------------------------------------------------------------------
module gq_color_checker (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    input  wire logic                     cfg_ready,
    input  wire logic [gq_pkg::CNT_W-1:0] sample_count,
    input  wire logic                     in_valid,
    input  wire logic                     in_ready,
    input  wire logic [gq_pkg::SUM_W-1:0] red_sum,
    input  wire logic [gq_pkg::SUM_W-1:0] green_sum,
    input  wire logic [gq_pkg::SUM_W-1:0] blue_sum,
    input  wire logic [2:0]               invalid_mask,
    input  wire logic                     out_valid,
    input  wire logic                     out_ready,
    input  wire logic [3*gq_pkg::ROOT_W-1:0] packed_color,
    output int                            mismatch_count,
    output int                            pending,
    output int                            colors_checked,
    output int                            saturated_bytes
);
    import gq_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [CNT_W-1:0]    live_count;
    logic [3*ROOT_W-1:0] expected_colors[$];

    // largest k with k*k*n <= sum, a zero count acting as one
    function automatic logic [ROOT_W-1:0] root_byte(logic [SUM_W-1:0] sum,
                                                    logic [CNT_W-1:0] n);
        logic [ROOT_W-1:0] k;
        logic [ROOT_W-1:0] trial;
        logic [63:0]       n_eff;
        logic [63:0]       square;
        n_eff = (n == 0) ? 64'd1 : 64'(n);
        k = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial  = k | (ROOT_W'(1) << b);
            square = 64'(trial) * 64'(trial) * n_eff;
            if (square <= 64'(sum))
                k = trial;
        end
        return k;
    endfunction

    // invalid channels are forced to zero before the root search
    function automatic logic [3*ROOT_W-1:0] predict_color(logic [SUM_W-1:0] r,
                                                          logic [SUM_W-1:0] g,
                                                          logic [SUM_W-1:0] b,
                                                          logic [2:0] mask,
                                                          logic [CNT_W-1:0] n);
        logic [SUM_W-1:0] r_eff;
        logic [SUM_W-1:0] g_eff;
        logic [SUM_W-1:0] b_eff;
        r_eff = mask[CH_RED] ? '0 : r;
        g_eff = mask[CH_GRN] ? '0 : g;
        b_eff = mask[CH_BLU] ? '0 : b;
        return {root_byte(r_eff, n), root_byte(g_eff, n), root_byte(b_eff, n)};
    endfunction

    // track the register, queue predictions, compare colors in order
    always @(posedge clk or negedge rst_n)
    begin
        logic [3*ROOT_W-1:0] want;
        if (!rst_n)
        begin
            live_count = CNT_W'(1);
            expected_colors.delete();
            mismatch_count  = 0;
            pending         = 0;
            colors_checked  = 0;
            saturated_bytes = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                live_count = sample_count;
            if (in_valid && in_ready)
            begin
                want = predict_color(red_sum, green_sum, blue_sum, invalid_mask,
                                     live_count);
                for (int ch = 0; ch < NUM_CH; ch++)
                    if (want[ch*ROOT_W +: ROOT_W] == '1)
                        saturated_bytes++;
                expected_colors.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("[%0t] color %h delivered with no pixel pending",
                                 $realtime, packed_color);
                end
                else
                begin
                    want = expected_colors.pop_front();
                    colors_checked++;
                    if (want[CH_RED*ROOT_W +: ROOT_W] != packed_color[CH_RED*ROOT_W +: ROOT_W]
                        || want[CH_GRN*ROOT_W +: ROOT_W]
                           != packed_color[CH_GRN*ROOT_W +: ROOT_W]
                        || want[CH_BLU*ROOT_W +: ROOT_W]
                           != packed_color[CH_BLU*ROOT_W +: ROOT_W])
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"[%0t] color %0d: expected r=%0d g=%0d b=%0d,",
                                      " got r=%0d g=%0d b=%0d"},
                                     $realtime, colors_checked,
                                     want[CH_RED*ROOT_W +: ROOT_W],
                                     want[CH_GRN*ROOT_W +: ROOT_W],
                                     want[CH_BLU*ROOT_W +: ROOT_W],
                                     packed_color[CH_RED*ROOT_W +: ROOT_W],
                                     packed_color[CH_GRN*ROOT_W +: ROOT_W],
                                     packed_color[CH_BLU*ROOT_W +: ROOT_W]);
                    end
                end
            end
            pending = expected_colors.size();
        end
    end

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb: testbench top for gamma2_color_quantizer_unit
// Drives pixel requests and sample count writes with random gaps and output
// back-pressure; a separate checker predicts and compares every color.
// ----------------------------------------------------------------------------
module tb;
    import gq_pkg::*;

    localparam int  CYCLE_LIMIT = 200000;
    localparam int  LONG_HOLD   = 200;
    localparam int  DRAIN_WAIT  = 20;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CNT_W-1:0]    sample_count;
    logic                in_valid;
    logic                in_ready;
    logic [SUM_W-1:0]    red_sum;
    logic [SUM_W-1:0]    green_sum;
    logic [SUM_W-1:0]    blue_sum;
    logic [2:0]          invalid_mask;
    logic                out_valid;
    logic                out_ready;
    logic [3*ROOT_W-1:0] packed_color;

    int mismatch_count;
    int pending;
    int colors_checked;
    int saturated_bytes;

    int          cycle_count = 0;
    int          pixels_sent;
    int          count_writes;
    int          hold_requests;
    int          holds_served = 0;
    bit          calm;
    logic [CNT_W-1:0] cur_count;

    gamma2_color_quantizer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .sample_count (sample_count),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .red_sum      (red_sum),
        .green_sum    (green_sum),
        .blue_sum     (blue_sum),
        .invalid_mask (invalid_mask),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .packed_color (packed_color)
    );

    gq_color_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .sample_count    (sample_count),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .red_sum         (red_sum),
        .green_sum       (green_sum),
        .blue_sum        (blue_sum),
        .invalid_mask    (invalid_mask),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .packed_color    (packed_color),
        .mismatch_count  (mismatch_count),
        .pending         (pending),
        .colors_checked  (colors_checked),
        .saturated_bytes (saturated_bytes)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // color receiver: random hold-offs, plus one long stall on request
    initial
    begin
        int  gap;
        bit  long_hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            long_hold = (holds_served < hold_requests);
            gap = calm ? 0 : $urandom_range(0, 7);
            if (long_hold)
                gap = gap + LONG_HOLD;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            if (long_hold)
                holds_served++;
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    // one pixel request, entered and left at a falling edge
    task automatic send_pixel(logic [SUM_W-1:0] r, logic [SUM_W-1:0] g,
                              logic [SUM_W-1:0] b, logic [2:0] mask);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        red_sum      <= r;
        green_sum    <= g;
        blue_sum     <= b;
        invalid_mask <= mask;
        do @(posedge clk); while (!(in_valid && in_ready));
        pixels_sent++;
        @(negedge clk);
    endtask

    // stop offering pixels until every color is back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // sample count write, only with the pipeline empty
    task automatic write_count(logic [CNT_W-1:0] value);
        drain();
        repeat (DRAIN_WAIT) @(negedge clk);
        cfg_valid    <= 1'b1;
        sample_count <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_count = value;
        count_writes++;
    endtask

    // channel sum aimed at root boundaries, saturation or full range
    function automatic logic [SUM_W-1:0] draw_sum(logic [CNT_W-1:0] n);
        logic [63:0] n_eff;
        logic [63:0] base;
        logic [63:0] pick;
        int          k;
        int          mode;
        n_eff = (n == 0) ? 64'd1 : 64'(n);
        k     = $urandom_range(0, 255);
        base  = 64'(k) * 64'(k) * n_eff;
        mode  = $urandom_range(0, 9);
        case (mode)
            0, 1, 2: pick = {$urandom, $urandom};
            3, 4:    pick = base;
            5:       pick = (base == 0) ? 64'd0 : base - 64'd1;
            6, 7:    pick = base + 64'($urandom_range(0, 2 * k + 1)) * n_eff;
            8:       pick = 64'($urandom_range(0, 65535));
            default: pick = 64'd65025 * n_eff + 64'($urandom_range(0, 2)) - 64'd1;
        endcase
        return pick[SUM_W-1:0];
    endfunction

    // mostly clean pixels, some with invalid channels
    function automatic logic [2:0] draw_mask();
        return ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
    endfunction

    task automatic run_random(int count, int pause_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                drain();
            send_pixel(draw_sum(cur_count), draw_sum(cur_count),
                       draw_sum(cur_count), draw_mask());
        end
    endtask

    // stimulus
    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        sample_count  = '0;
        in_valid      = 1'b0;
        red_sum       = '0;
        green_sum     = '0;
        blue_sum      = '0;
        invalid_mask  = '0;
        pixels_sent   = 0;
        count_writes  = 0;
        hold_requests = 0;
        calm          = 1'b0;
        cur_count     = CNT_W'(1);
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed at the reset count of one
        send_pixel('0, '0, '0, 3'd0);
        send_pixel(SUM_MAX, SUM_MAX, SUM_MAX, 3'd0);
        for (int m = 1; m < 8; m++)
            send_pixel(SUM_MAX, SUM_MAX, SUM_MAX, 3'(m));
        send_pixel(40'd65025, 40'd65024, 40'd65026, 3'd0);
        send_pixel(40'd1, 40'd0, 40'd3, 3'd0);
        send_pixel(40'd4, 40'd8, 40'd9, 3'd0);
        send_pixel(40'd16384, 40'd16383, 40'd16129, 3'd0);
        send_pixel(40'd1 << 39, 40'd1 << 24, 40'd1 << 16, 3'd0);

        // zero count behaves as one
        write_count('0);
        send_pixel(40'd65025, 40'd65024, SUM_MAX, 3'd0);
        send_pixel(40'd2, 40'd3, 40'd4, 3'd5);
        run_random(80, 40);

        // largest count, back to back
        write_count('1);
        calm = 1'b1;
        send_pixel(40'd65025 * 40'd65535, 40'd65025 * 40'd65535 - 40'd1, SUM_MAX, 3'd0);
        send_pixel(40'd65535, 40'd65534, 40'd4 * 40'd65535, 3'd0);
        send_pixel(40'd65025 * 40'd65535, SUM_MAX, 40'd0, 3'd7);
        run_random(80, -1);
        calm = 1'b0;

        // long output stall while pixels keep coming
        write_count(CNT_W'(1));
        hold_requests++;
        run_random(100, 60);

        write_count(CNT_W'($urandom_range(2, 7)));
        run_random(100, -1);

        write_count(CNT_W'($urandom_range(100, 2000)));
        calm = 1'b1;
        run_random(40, -1);
        calm = 1'b0;
        run_random(60, -1);

        write_count(CNT_W'($urandom_range(1, 65535)));
        run_random(100, -1);

        write_count(CNT_W'(3));
        run_random(60, -1);

        drain();
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("sent %0d pixels over %0d sample count writes (zero and full scale included)",
                 pixels_sent, count_writes);
        $display("checked %0d colors, %0d channel bytes saturated, %0d mismatches",
                 colors_checked, saturated_bytes, mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
